>>> design/assert_macros.svh
// Assertion macros shared by the checker files.
// Needs clk and rst_n visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ADDU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled during reset.
`define ADDU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

>>> design/addu_pkg.sv
// Shared constants and helpers for the acrobot derivative unit.
// No dependencies.
`timescale 1ns / 1ps

package addu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int DAMP_W        = 21;
    localparam int CFG_IDX_W     = 8;
    localparam int SIN_STAGES    = 6;
    localparam int HORNER_STEPS  = 4;
    localparam int DIV_STAGES    = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SHOULDER_DAMPING = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ELBOW_DAMPING    = 8'd1;

    localparam logic [DAMP_W-1:0] DAMP_RESET = 21'd26214;

    localparam logic signed [30:0] K_TURN = 31'sd683565276;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [30:0] S_A9    = 31'd172272;
    localparam logic [30:0] SIN_COEF [HORNER_STEPS] = '{
        31'd5026995, 31'd85569306, 31'd693598669, 31'd1686629713
    };

    localparam longint Q32_THIRD       = 64'sd1431655765;
    localparam longint Q32_FIVE_THIRDS = 64'sd7158278827;
    localparam longint Q32_G_SHOULDER  = 64'sd63136019251;
    localparam longint Q32_G_HALF      = 64'sd21045339750;

    // Round a Q32 constant to f fraction bits.
    function automatic longint kq(input longint q32, input int f);
        return (q32 + (longint'(1) <<< (31 - f))) >>> (32 - f);
    endfunction

endpackage

>>> design/acrobot_dynamics_derivative_unit.sv
// Acrobot state derivative: top level, pipelined at one state per cycle unless m_tready stalls it.
// Depends on addu_pkg, addu_sin and addu_div.
//
// Usage:
//   Input stream s_*: one request per accepted beat carries both joint angles,
//   both joint velocities and the elbow torque, signed Q(32-FRAC_BITS).FRAC_BITS.
//   Output stream m_*: one result per request, in order: the two velocities,
//   the two saturated accelerations, and the saturation flag on m_tuser.
//   Config channel cfg_*: index 0 writes shoulder damping, index 1 elbow
//   damping; cfg_ready is always high. Write only while the pipeline is empty.
// Timing:
//   Stages from input accept to result valid: 1 turn multiply,
//   6 sine stages, 5 dynamics stages, 32 divider stages, 1 output register.
//   Throughput is one request per cycle while m_tready does not stall the
//   output; the 32-stage restoring divider sets the depth.
// Reset: rst_n low empties the pipeline and loads both damping registers
//   with 0.4. When m_tready is low with a result waiting, the whole pipeline
//   holds and s_tready drops in the same cycle; nothing is lost or repeated.
`timescale 1ns / 1ps

module acrobot_dynamics_derivative_unit
    import addu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // shoulder_angle, shoulder_velocity, elbow_angle, elbow_velocity, elbow_torque
    input  logic [159:0]         s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // shoulder_angle_rate, shoulder_accel, elbow_angle_rate, elbow_accel
    output logic [127:0]         m_tdata,
    // saturated
    output logic [0:0]           m_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DAMP_W-1:0]    cfg_data
);

    localparam int F   = FRAC_BITS;
    localparam int SW  = F + 2;
    localparam int HW  = F + 3;
    localparam int KW  = F + 5;
    localparam int MW  = SW + DATA_W;
    localparam int CW  = MW - F;
    localparam int BW  = CW + 1;
    localparam int PW  = BW + DATA_W;
    localparam int GW  = KW + SW;
    localparam int DDW = 2 * HW;
    localparam int EW  = 70 - F;
    localparam int TW  = 60 - F;
    localparam int NW  = 64;
    localparam int DW  = F + 1;
    localparam int NST = 1 + SIN_STAGES + 5 + DIV_STAGES + 1;

    localparam logic signed [HW-1:0] K_THIRD       = HW'(kq(Q32_THIRD, F));
    localparam logic signed [HW-1:0] K_FIVE_THIRDS = HW'(kq(Q32_FIVE_THIRDS, F));
    localparam logic signed [KW-1:0] K_G_SHOULDER  = KW'(kq(Q32_G_SHOULDER, F));
    localparam logic signed [KW-1:0] K_G_HALF      = KW'(kq(Q32_G_HALF, F));
    localparam logic signed [EW-1:0] T_LIM         = EW'(longint'(1) <<< (58 - F));
    localparam logic [31:0] INT_MIN_MAG = 32'h8000_0000;
    localparam logic [31:0] INT_MAX_VAL = 32'h7FFF_FFFF;

    logic en;
    logic [NST-1:0] vld_reg;
    logic [DAMP_W-1:0] damp0_reg;
    logic [DAMP_W-1:0] damp1_reg;

    logic signed [31:0] in_q1, in_qd1, in_q2, in_qd2, in_u;
    logic signed [61:0] pa1, pa2;

    // stage A and sine alignment
    logic [31:0] ph1_reg, ph2_reg;
    logic signed [31:0] a_qd1_reg [SIN_STAGES+1];
    logic signed [31:0] a_qd2_reg [SIN_STAGES+1];
    logic signed [31:0] a_u_reg   [SIN_STAGES+1];
    logic signed [SW-1:0] sn1, sn2, cs2, sn12;

    // stage C
    logic signed [MW-1:0] p22, p21;
    logic signed [GW-1:0] pg1, pgs;
    logic signed [HW-1:0] c_h00_reg, c_h01_reg;
    logic signed [CW-1:0] c_m22_reg, c_c01_reg, c_c10_reg;
    logic signed [GW-F-1:0] c_g1_reg, c_gs_reg;
    logic signed [31:0] c_qd1_reg, c_qd2_reg, c_u_reg;

    // stage D
    logic signed [BW-1:0] c00;
    logic signed [PW-1:0] pc0, pc1, pc2, pc3;
    logic signed [DDW-1:0] d_hh0_reg, d_hh1_reg;
    logic signed [EW-1:0] d_p0_reg, d_p1_reg, d_p2_reg, d_p3_reg, d_g0_reg, d_g1_reg;
    logic signed [HW-1:0] d_h00_reg, d_h01_reg;
    logic signed [31:0] d_qd1_reg, d_qd2_reg, d_u_reg;

    // stage E
    logic signed [EW-1:0] t0_raw, t1_raw, t0_cl, t1_cl;
    logic t_clip;
    logic signed [DDW-1:0] dd;
    logic signed [DDW-F-1:0] det_raw;
    logic signed [TW-1:0] e_t0_reg, e_t1_reg;
    logic e_flag_reg;
    logic [DW-1:0] e_det_reg;
    logic signed [HW-1:0] e_h00_reg, e_h01_reg;
    logic signed [31:0] e_qd1_reg, e_qd2_reg;

    // stage F
    logic signed [NW-1:0] f_m0_reg, f_m1_reg, f_m2_reg, f_m3_reg;
    logic f_flag_reg;
    logic [DW-1:0] f_det_reg;
    logic signed [31:0] f_qd1_reg, f_qd2_reg;

    // stage G
    logic signed [NW-1:0] n0, n1;
    logic [NW-1:0] mag0, mag1;
    logic [31:0] g_lo0_reg, g_lo1_reg;
    logic [DW-1:0] g_rem0_reg, g_rem1_reg, g_det_reg;

    // divider alignment
    logic        v_neg0_reg [DIV_STAGES+1];
    logic        v_neg1_reg [DIV_STAGES+1];
    logic        v_ovf0_reg [DIV_STAGES+1];
    logic        v_ovf1_reg [DIV_STAGES+1];
    logic        v_flag_reg [DIV_STAGES+1];
    logic [31:0] v_qd1_reg  [DIV_STAGES+1];
    logic [31:0] v_qd2_reg  [DIV_STAGES+1];
    logic [31:0] quo0, quo1;

    // stage H
    logic big0, big1;
    logic [31:0] acc0, acc1;
    logic [127:0] out_data_reg;
    logic out_sat_reg;

    assign en        = !vld_reg[NST-1] || m_tready;
    assign s_tready  = en;
    assign m_tvalid  = vld_reg[NST-1];
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_sat_reg;
    assign cfg_ready = 1'b1;

    assign in_q1  = s_tdata[31:0];
    assign in_qd1 = s_tdata[63:32];
    assign in_q2  = s_tdata[95:64];
    assign in_qd2 = s_tdata[127:96];
    assign in_u   = s_tdata[159:128];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            damp0_reg <= DAMP_RESET;
            damp1_reg <= DAMP_RESET;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[NST-2:0], s_tvalid};
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_SHOULDER_DAMPING: damp0_reg <= cfg_data;
                    REG_ELBOW_DAMPING:    damp1_reg <= cfg_data;
                    default:              ;
                endcase
            end
        end
    end

    // stage A: angle to turn
    assign pa1 = 62'(in_q1) * 62'(K_TURN);
    assign pa2 = 62'(in_q2) * 62'(K_TURN);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph1_reg      <= pa1[F+31:F];
            ph2_reg      <= pa2[F+31:F];
            a_qd1_reg[0] <= in_qd1;
            a_qd2_reg[0] <= in_qd2;
            a_u_reg[0]   <= in_u;
            for (int k = 1; k <= SIN_STAGES; k++)
            begin
                a_qd1_reg[k] <= a_qd1_reg[k-1];
                a_qd2_reg[k] <= a_qd2_reg[k-1];
                a_u_reg[k]   <= a_u_reg[k-1];
            end
        end
    end

    addu_sin #(.FRAC_BITS(F)) u_sin_s1
    (
        .clk(clk), .en(en), .phase(ph1_reg), .sine(sn1)
    );
    addu_sin #(.FRAC_BITS(F)) u_sin_s2
    (
        .clk(clk), .en(en), .phase(ph2_reg), .sine(sn2)
    );
    addu_sin #(.FRAC_BITS(F)) u_sin_c2
    (
        .clk(clk), .en(en), .phase(ph2_reg + 32'h4000_0000), .sine(cs2)
    );
    addu_sin #(.FRAC_BITS(F)) u_sin_s12
    (
        .clk(clk), .en(en), .phase(ph1_reg + ph2_reg), .sine(sn12)
    );

    // stage C: mass matrix, velocity products, gravity
    assign p22 = MW'(sn2) * MW'(a_qd2_reg[SIN_STAGES]);
    assign p21 = MW'(sn2) * MW'(a_qd1_reg[SIN_STAGES]);
    assign pg1 = GW'(K_G_HALF) * GW'(sn12);
    assign pgs = GW'(K_G_SHOULDER) * GW'(sn1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_h00_reg <= K_FIVE_THIRDS + HW'(cs2);
            c_h01_reg <= K_THIRD + HW'(cs2 >>> 1);
            c_m22_reg <= CW'(p22 >>> F);
            c_c01_reg <= -CW'(p22 >>> (F + 1));
            c_c10_reg <= CW'(p21 >>> (F + 1));
            c_g1_reg  <= (GW-F)'(pg1 >>> F);
            c_gs_reg  <= (GW-F)'(pgs >>> F);
            c_qd1_reg <= a_qd1_reg[SIN_STAGES];
            c_qd2_reg <= a_qd2_reg[SIN_STAGES];
            c_u_reg   <= a_u_reg[SIN_STAGES];
        end
    end

    // stage D: Coriolis and damping products, determinant products
    assign c00 = BW'(signed'({1'b0, damp0_reg})) - BW'(c_m22_reg);
    assign pc0 = PW'(c00) * PW'(c_qd1_reg);
    assign pc1 = PW'(c_c01_reg) * PW'(c_qd2_reg);
    assign pc2 = PW'(c_c10_reg) * PW'(c_qd1_reg);
    assign pc3 = PW'(signed'({1'b0, damp1_reg})) * PW'(c_qd2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_hh0_reg <= DDW'(c_h00_reg) * DDW'(K_THIRD);
            d_hh1_reg <= DDW'(c_h01_reg) * DDW'(c_h01_reg);
            d_p0_reg  <= EW'(pc0 >>> F);
            d_p1_reg  <= EW'(pc1 >>> F);
            d_p2_reg  <= EW'(pc2 >>> F);
            d_p3_reg  <= EW'(pc3 >>> F);
            d_g0_reg  <= EW'(c_gs_reg) + EW'(c_g1_reg);
            d_g1_reg  <= EW'(c_g1_reg);
            d_h00_reg <= c_h00_reg;
            d_h01_reg <= c_h01_reg;
            d_qd1_reg <= c_qd1_reg;
            d_qd2_reg <= c_qd2_reg;
            d_u_reg   <= c_u_reg;
        end
    end

    // stage E: torque balance with clip, determinant
    always_comb
    begin
        t0_raw = -(d_p0_reg + d_p1_reg) - d_g0_reg;
        t1_raw = EW'(d_u_reg) - (d_p2_reg + d_p3_reg) - d_g1_reg;
        t_clip = 1'b0;
        t0_cl  = t0_raw;
        t1_cl  = t1_raw;
        if (t0_raw > T_LIM)
        begin
            t0_cl  = T_LIM;
            t_clip = 1'b1;
        end
        else if (t0_raw < -T_LIM)
        begin
            t0_cl  = -T_LIM;
            t_clip = 1'b1;
        end
        if (t1_raw > T_LIM)
        begin
            t1_cl  = T_LIM;
            t_clip = 1'b1;
        end
        else if (t1_raw < -T_LIM)
        begin
            t1_cl  = -T_LIM;
            t_clip = 1'b1;
        end
        dd      = d_hh0_reg - d_hh1_reg;
        det_raw = (DDW-F)'(dd >>> F);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_t0_reg   <= TW'(t0_cl);
            e_t1_reg   <= TW'(t1_cl);
            e_flag_reg <= t_clip;
            e_det_reg  <= (det_raw < 1) ? DW'(1) : DW'(det_raw);
            e_h00_reg  <= d_h00_reg;
            e_h01_reg  <= d_h01_reg;
            e_qd1_reg  <= d_qd1_reg;
            e_qd2_reg  <= d_qd2_reg;
        end
    end

    // stage F: adjugate products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_m0_reg   <= NW'(K_THIRD) * NW'(e_t0_reg);
            f_m1_reg   <= NW'(e_h01_reg) * NW'(e_t1_reg);
            f_m2_reg   <= NW'(e_h00_reg) * NW'(e_t1_reg);
            f_m3_reg   <= NW'(e_h01_reg) * NW'(e_t0_reg);
            f_flag_reg <= e_flag_reg;
            f_det_reg  <= e_det_reg;
            f_qd1_reg  <= e_qd1_reg;
            f_qd2_reg  <= e_qd2_reg;
        end
    end

    // stage G: numerators, magnitude, overflow precheck
    always_comb
    begin
        n0   = f_m0_reg - f_m1_reg;
        n1   = f_m2_reg - f_m3_reg;
        mag0 = n0[NW-1] ? $unsigned(-n0) : $unsigned(n0);
        mag1 = n1[NW-1] ? $unsigned(-n1) : $unsigned(n1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_lo0_reg     <= mag0[31:0];
            g_lo1_reg     <= mag1[31:0];
            g_rem0_reg    <= mag0[DW+31:32];
            g_rem1_reg    <= mag1[DW+31:32];
            g_det_reg     <= f_det_reg;
            v_neg0_reg[0] <= n0[NW-1];
            v_neg1_reg[0] <= n1[NW-1];
            v_ovf0_reg[0] <= (mag0[63:32] >= 32'(f_det_reg));
            v_ovf1_reg[0] <= (mag1[63:32] >= 32'(f_det_reg));
            v_flag_reg[0] <= f_flag_reg;
            v_qd1_reg[0]  <= f_qd1_reg;
            v_qd2_reg[0]  <= f_qd2_reg;
            for (int k = 1; k <= DIV_STAGES; k++)
            begin
                v_neg0_reg[k] <= v_neg0_reg[k-1];
                v_neg1_reg[k] <= v_neg1_reg[k-1];
                v_ovf0_reg[k] <= v_ovf0_reg[k-1];
                v_ovf1_reg[k] <= v_ovf1_reg[k-1];
                v_flag_reg[k] <= v_flag_reg[k-1];
                v_qd1_reg[k]  <= v_qd1_reg[k-1];
                v_qd2_reg[k]  <= v_qd2_reg[k-1];
            end
        end
    end

    addu_div #(.DW(DW)) u_div0
    (
        .clk(clk), .en(en), .mag_lo(g_lo0_reg), .rem_in(g_rem0_reg),
        .den(g_det_reg), .quo(quo0)
    );
    addu_div #(.DW(DW)) u_div1
    (
        .clk(clk), .en(en), .mag_lo(g_lo1_reg), .rem_in(g_rem1_reg),
        .den(g_det_reg), .quo(quo1)
    );

    // stage H: sign, saturate, output register
    always_comb
    begin
        big0 = v_ovf0_reg[DIV_STAGES]
            || (v_neg0_reg[DIV_STAGES] ? (quo0 > INT_MIN_MAG) : quo0[31]);
        big1 = v_ovf1_reg[DIV_STAGES]
            || (v_neg1_reg[DIV_STAGES] ? (quo1 > INT_MIN_MAG) : quo1[31]);
        if (big0)
        begin
            acc0 = v_neg0_reg[DIV_STAGES] ? INT_MIN_MAG : INT_MAX_VAL;
        end
        else
        begin
            acc0 = v_neg0_reg[DIV_STAGES] ? -quo0 : quo0;
        end
        if (big1)
        begin
            acc1 = v_neg1_reg[DIV_STAGES] ? INT_MIN_MAG : INT_MAX_VAL;
        end
        else
        begin
            acc1 = v_neg1_reg[DIV_STAGES] ? -quo1 : quo1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {acc1, v_qd2_reg[DIV_STAGES], acc0, v_qd1_reg[DIV_STAGES]};
            out_sat_reg  <= v_flag_reg[DIV_STAGES] || big0 || big1;
        end
    end

endmodule

>>> design/addu_sin.sv
// Pipelined sine of a Q0.32 turn, odd polynomial through x^9.
// Depends on addu_pkg. Takes one phase per cycle while en is high.
`timescale 1ns / 1ps

module addu_sin
    import addu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [31:0]                   phase,
    output logic signed [FRAC_BITS+1:0]   sine
);

    localparam int SW = FRAC_BITS + 2;

    logic [30:0] x_reg    [HORNER_STEPS+1];
    logic [30:0] x2_reg   [HORNER_STEPS+1];
    logic [30:0] p_reg    [HORNER_STEPS+1];
    logic [1:0]  quad_reg [HORNER_STEPS+1];
    logic signed [SW-1:0] sine_reg;

    logic [30:0] x_in;
    logic [61:0] sq;
    logic [61:0] fin_prod;
    logic [31:0] s_raw;
    logic [30:0] s_cl;
    logic [FRAC_BITS:0] mag;

    always_comb
    begin
        x_in = phase[30] ? (Q30_ONE - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
        sq   = 62'(x_in) * 62'(x_in);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_in;
            x2_reg[0]   <= sq[60:30];
            p_reg[0]    <= S_A9;
            quad_reg[0] <= phase[31:30];
        end
    end

    for (genvar k = 0; k < HORNER_STEPS; k++)
    begin : g_horner
        logic [61:0] prod;
        assign prod = 62'(p_reg[k]) * 62'(x2_reg[k]);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[k+1]    <= SIN_COEF[k] - prod[60:30];
                x_reg[k+1]    <= x_reg[k];
                x2_reg[k+1]   <= x2_reg[k];
                quad_reg[k+1] <= quad_reg[k];
            end
        end
    end

    always_comb
    begin
        fin_prod = 62'(x_reg[HORNER_STEPS]) * 62'(p_reg[HORNER_STEPS]);
        s_raw    = fin_prod[61:30];
        s_cl     = (s_raw > 32'(Q30_ONE)) ? Q30_ONE : s_raw[30:0];
        mag      = s_cl[30:30-FRAC_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sine_reg <= quad_reg[HORNER_STEPS][1] ? -signed'({1'b0, mag})
                                                  : signed'({1'b0, mag});
        end
    end

    assign sine = sine_reg;

endmodule

>>> design/addu_div.sv
// Restoring divider, one quotient bit per stage, 32 stages.
// Depends on addu_pkg. Quotient must be known to fit 32 bits.
`timescale 1ns / 1ps

module addu_div
    import addu_pkg::*;
#(
    parameter int DW = FRAC_BITS_DEF + 1
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [31:0]   mag_lo,
    input  logic [DW-1:0] rem_in,
    input  logic [DW-1:0] den,
    output logic [31:0]   quo
);

    logic [DW-1:0] r_reg [DIV_STAGES];
    logic [DW-1:0] d_reg [DIV_STAGES];
    logic [31:0]   m_reg [DIV_STAGES];
    logic [31:0]   q_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        logic [DW-1:0] r_cur;
        logic [DW-1:0] d_cur;
        logic [31:0]   m_cur;
        logic [31:0]   q_cur;
        logic [DW:0]   rs;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign r_cur = rem_in;
            assign d_cur = den;
            assign m_cur = mag_lo;
            assign q_cur = '0;
        end
        else
        begin : g_rest
            assign r_cur = r_reg[k-1];
            assign d_cur = d_reg[k-1];
            assign m_cur = m_reg[k-1];
            assign q_cur = q_reg[k-1];
        end

        assign rs = {r_cur, m_cur[31-k]};
        assign ge = (rs >= {1'b0, d_cur});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k] <= ge ? DW'(rs - {1'b0, d_cur}) : rs[DW-1:0];
                d_reg[k] <= d_cur;
                m_reg[k] <= m_cur;
                q_reg[k] <= {q_cur[30:0], ge};
            end
        end
    end

    assign quo = q_reg[DIV_STAGES-1];

endmodule

>>> design/addu_chk.sv
// Port-level checks for the acrobot derivative unit, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module addu_chk
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [0:0]   m_tuser
);

    `ADDU_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
    `ADDU_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
    `ADDU_ASSERT_NOW(a_ready_stall, s_tvalid || !s_tvalid, s_tready == (!m_tvalid || m_tready))
    `ADDU_ASSERT_NOW(a_reset_empty, $rose(rst_n), !m_tvalid)

endmodule

bind acrobot_dynamics_derivative_unit addu_chk u_addu_chk (.*);
